// ===== hdl/twm_pkg.sv =====
// twm_pkg: shared types and constants for the two-way sorted merge
// depends on nothing; used by twm_cell, twm_list and two_way_sorted_merge

package twm_pkg;

	// elements kept per list, range 1 to 32
	localparam int LIST_DEPTH = 16;
	// element count, 0 .. LIST_DEPTH
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);

	typedef logic signed [31:0] elem_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	// control from the merge sequencer to one list
	typedef struct packed {
		logic push;
		logic pop;
	} list_ctrl_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} merge_state_t;

endpackage

// ===== hdl/twm_cell.sv =====
// twm_cell: one storage cell of a list chain
// depends on twm_pkg

module twm_cell (
	input  logic           clk,
	input  logic           load,
	input  logic           shift,
	input  twm_pkg::elem_t load_value,
	input  twm_pkg::elem_t next_value,
	output twm_pkg::elem_t data
);

	twm_pkg::elem_t data_q;

	// shift toward the head on pop, else take a new element at the tail
	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= next_value;
		end else if (load) begin
			data_q <= load_value;
		end
	end

	assign data = data_q;

endmodule

// ===== hdl/twm_list.sv =====
// twm_list: one sorted list held as a chain of cells, head at cell zero
// depends on twm_pkg and twm_cell

module twm_list (
	input  logic                 clk,
	input  logic                 arst_n,
	input  twm_pkg::list_ctrl_t  ctrl,
	input  twm_pkg::elem_t       push_value,
	output twm_pkg::elem_t       head,
	output twm_pkg::cnt_t        count
);

	twm_pkg::elem_t cell_data [twm_pkg::LIST_DEPTH];
	twm_pkg::cnt_t  count_q;

	for (genvar i = 0; i < twm_pkg::LIST_DEPTH; i++) begin : g_cell
		twm_pkg::elem_t next_value;

		if (i < twm_pkg::LIST_DEPTH - 1) begin : g_mid
			assign next_value = cell_data[i+1];
		end else begin : g_tail
			assign next_value = cell_data[i];
		end

		twm_cell u_cell (
			.clk        (clk),
			.load       (ctrl.push && (count_q == twm_pkg::CNT_W'(i))),
			.shift      (ctrl.pop),
			.load_value (push_value),
			.next_value (next_value),
			.data       (cell_data[i])
		);
	end

	// the caller must push only while below depth and pop only while nonempty; the list does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.push) begin
			count_q <= count_q + twm_pkg::CNT_W'(1);
		end else if (ctrl.pop) begin
			count_q <= count_q - twm_pkg::CNT_W'(1);
		end
	end

	assign head  = cell_data[0];
	assign count = count_q;

endmodule

// ===== hdl/two_way_sorted_merge.sv =====
// two_way_sorted_merge: merges two sorted lists of signed 32-bit values
// depends on twm_pkg and twm_list (which uses twm_cell)
//
// channel   handshake                  payload
// item      item_valid / item_ready    req_type, value, has_value, list_end
// result    result_valid / result_ready merged_value, out_valid, run_last, overflow
//
// loading takes one request per cycle while the block is in its load phase
// the request that closes the later of the two lists starts the drain, entered in
// the next cycle; then one result per cycle, set by the single compare of the two
// chain heads; no request is taken during the drain, which lasts count1 + count2
// results (one result for two empty lists); a full, unread result register stalls it
// reset clears counts, end flags, drop flag and the result valid flag

module two_way_sorted_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic                  req_type,
	input  logic signed [31:0]    value,
	input  logic                  has_value,
	input  logic                  list_end,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic signed [31:0]    merged_value,
	output logic                  out_valid,
	output logic                  run_last,
	output logic                  overflow
);

	twm_pkg::merge_state_t state_q, state_d;

	twm_pkg::list_ctrl_t first_ctrl, second_ctrl;
	twm_pkg::elem_t      first_head, second_head;
	twm_pkg::cnt_t       first_cnt, second_cnt;

	logic first_ended_q, second_ended_q;
	logic dropped_q;

	// result register
	logic                res_v_q;
	twm_pkg::elem_t      res_value_q;
	logic                res_valid_q;
	logic                res_last_q;
	logic                res_ovf_q;

	logic                accept;
	logic                sel_ended;
	logic                sel_full;
	logic                other_ended;
	logic                slot_free;
	logic                emit;
	logic                emit_empty;
	logic                take_first;
	logic                emit_last;
	logic [twm_pkg::CNT_W:0] total;
	logic                close_pair;
	logic                clear_run;

	twm_list u_first (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (first_ctrl),
		.push_value (value),
		.head       (first_head),
		.count      (first_cnt)
	);

	twm_list u_second (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (second_ctrl),
		.push_value (value),
		.head       (second_head),
		.count      (second_cnt)
	);

	assign accept      = item_valid && item_ready;
	assign sel_ended   = req_type ? second_ended_q : first_ended_q;
	assign other_ended = req_type ? first_ended_q : second_ended_q;
	assign sel_full    = (req_type ? second_cnt : first_cnt) == twm_pkg::CNT_W'(twm_pkg::LIST_DEPTH);
	assign slot_free   = !res_v_q || result_ready;
	assign total       = {1'b0, first_cnt} + {1'b0, second_cnt};

	// head compare: first list wins ties, an empty list never wins
	assign take_first = (first_cnt != '0) &&
		((second_cnt == '0) || (first_head <= second_head));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twm_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state, list pushes and pops, result loads
	always_comb begin
		state_d     = state_q;
		item_ready  = 1'b0;
		first_ctrl  = '0;
		second_ctrl = '0;
		emit        = 1'b0;
		emit_empty  = 1'b0;
		emit_last   = 1'b0;
		close_pair  = 1'b0;
		clear_run   = 1'b0;
		case (state_q)
			twm_pkg::ST_LOAD: begin
				item_ready = 1'b1;
				// a request for an already closed list is ignored entirely
				if (accept && !sel_ended) begin
					if (has_value && !sel_full) begin
						first_ctrl.push  = !req_type;
						second_ctrl.push = req_type;
					end
					if (list_end && other_ended) begin
						close_pair = 1'b1;
						state_d    = twm_pkg::ST_DRAIN;
					end
				end
			end
			twm_pkg::ST_DRAIN: begin
				if (slot_free) begin
					emit = 1'b1;
					if (total == '0) begin
						// two empty lists give one empty result
						emit_empty = 1'b1;
						emit_last  = 1'b1;
					end else begin
						first_ctrl.pop  = take_first;
						second_ctrl.pop = !take_first;
						emit_last       = (total == (twm_pkg::CNT_W + 1)'(1));
					end
					if (emit_last) begin
						clear_run = 1'b1;
						state_d   = twm_pkg::ST_LOAD;
					end
				end
			end
			default: begin
				state_d = twm_pkg::ST_LOAD;
			end
		endcase
	end

	// end flags and drop flag, cleared when the run's last result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_ended_q  <= 1'b0;
			second_ended_q <= 1'b0;
			dropped_q      <= 1'b0;
		end else if (clear_run) begin
			first_ended_q  <= 1'b0;
			second_ended_q <= 1'b0;
			dropped_q      <= 1'b0;
		end else if (accept && !sel_ended) begin
			if (has_value && sel_full) begin
				dropped_q <= 1'b1;
			end
			if (list_end) begin
				if (req_type) begin
					second_ended_q <= 1'b1;
				end else begin
					first_ended_q <= 1'b1;
				end
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (emit) begin
			res_v_q <= 1'b1;
		end else if (result_ready) begin
			res_v_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			res_value_q <= emit_empty ? '0 : (take_first ? first_head : second_head);
			res_valid_q <= !emit_empty;
			res_last_q  <= emit_last;
			res_ovf_q   <= dropped_q;
		end
	end

	assign result_valid = res_v_q;
	assign merged_value = res_value_q;
	assign out_valid    = res_valid_q;
	assign run_last     = res_last_q;
	assign overflow     = res_ovf_q;

	// both lists are closed for the whole drain
	a_drain_closed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == twm_pkg::ST_DRAIN |-> (first_ended_q && second_ended_q))
		else $error("drain without both lists closed");

	// loading never sees both lists closed
	a_load_open: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == twm_pkg::ST_LOAD |-> !(first_ended_q && second_ended_q))
		else $error("both lists closed while loading");

	// chains never hold more than their depth
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(first_cnt <= twm_pkg::CNT_W'(twm_pkg::LIST_DEPTH)) &&
		(second_cnt <= twm_pkg::CNT_W'(twm_pkg::LIST_DEPTH)))
		else $error("list count beyond depth");

	// loading the run's last result leaves the sequencer idle with both chains empty
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=>
		(state_q == twm_pkg::ST_LOAD && first_cnt == '0 && second_cnt == '0 &&
		!first_ended_q && !second_ended_q))
		else $error("run ended with elements left");

	// a closing pair request enters the drain at the next edge
	a_close_drain: assert property (@(posedge clk) disable iff (!arst_n)
		close_pair |=> state_q == twm_pkg::ST_DRAIN)
		else $error("closing request did not start the drain");

endmodule
